// ===== rtl/bts_pkg.sv =====
package bts_pkg;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_RESTART = 2'd1,
        OP_STEP    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_EX
    } state_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_LOAD  = 8'h3B;
    localparam logic [7:0] CH_EMIT  = 8'h3A;

    typedef struct packed {
        logic append;
        logic clear;
    } prog_cmd_t;

    typedef struct packed {
        logic sweep;
        logic ptr_zero;
        logic ptr_inc;
        logic ptr_dec;
        logic wr;
    } tape_cmd_t;

    typedef struct packed {
        logic sweep_last;
    } tape_stat_t;

endpackage

// ===== rtl/bts_prog_store.sv =====
module bts_prog_store #(
    parameter int PROG_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bts_pkg::prog_cmd_t                cmd,
    input  logic [7:0]                        wchar,
    input  logic [$clog2(PROG_DEPTH)-1:0]     raddr,
    output logic [7:0]                        rdata,
    output logic [$clog2(PROG_DEPTH+1)-1:0]   len,
    output logic                              full
);

    localparam int PC_W = $clog2(PROG_DEPTH + 1);
    localparam int PA_W = $clog2(PROG_DEPTH);

    logic [7:0]      mem [PROG_DEPTH];
    logic [7:0]      rdata_reg;
    logic [PC_W-1:0] len_reg;
    logic [PC_W-1:0] len_next;
    logic            wr_en;

    assign full  = (len_reg == PC_W'(PROG_DEPTH));
    assign wr_en = cmd.append && !full;
    assign len   = len_reg;
    assign rdata = rdata_reg;

    always_comb
    begin
        len_next = len_reg;
        if (cmd.clear)
        begin
            len_next = '0;
        end
        else if (wr_en)
        begin
            len_next = len_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[PA_W-1:0]] <= wchar;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== rtl/bts_tape.sv =====
module bts_tape #(
    parameter int NUM_CELLS = 16,
    parameter int CELL_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bts_pkg::tape_cmd_t   cmd,
    input  logic [CELL_BITS-1:0] wdata,
    output logic [CELL_BITS-1:0] rdata,
    output bts_pkg::tape_stat_t  stat
);

    localparam int PTR_W = $clog2(NUM_CELLS);

    logic [CELL_BITS-1:0] mem [NUM_CELLS];
    logic [CELL_BITS-1:0] rdata_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [PTR_W-1:0]     sweep_reg;
    logic [PTR_W-1:0]     sweep_next;
    logic                 sweep_last;
    logic                 ptr_last;
    logic                 we;
    logic [PTR_W-1:0]     waddr;
    logic [CELL_BITS-1:0] wd;

    assign sweep_last      = (sweep_reg == PTR_W'(NUM_CELLS - 1));
    assign ptr_last        = (ptr_reg == PTR_W'(NUM_CELLS - 1));
    assign stat.sweep_last = sweep_last;
    assign rdata           = rdata_reg;

    // clearing pass owns the write port while it runs
    assign we    = cmd.sweep || cmd.wr;
    assign waddr = cmd.sweep ? sweep_reg : ptr_reg;
    assign wd    = cmd.sweep ? '0 : wdata;

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep)
        begin
            sweep_next = sweep_last ? '0 : sweep_reg + PTR_W'(1);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        priority if (cmd.ptr_zero)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_last ? '0 : ptr_reg + PTR_W'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = (ptr_reg == '0) ? PTR_W'(NUM_CELLS - 1) : ptr_reg - PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wd;
        end
        rdata_reg <= mem[ptr_reg];
    end

endmodule

// ===== rtl/bts_ctrl.sv =====
module bts_ctrl #(
    parameter int PROG_DEPTH = 1024,
    parameter int CELL_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic signed [31:0]                input_value,
    output logic                              done,
    output logic                              out_valid,
    output logic signed [31:0]                out_value,
    output logic                              took_input,
    output logic                              halted,
    output logic                              load_full,
    output logic [10:0]                       program_counter,
    output bts_pkg::prog_cmd_t                prog_cmd,
    output logic [$clog2(PROG_DEPTH)-1:0]     prog_raddr,
    input  logic [7:0]                        prog_rdata,
    input  logic [$clog2(PROG_DEPTH+1)-1:0]   prog_len,
    input  logic                              prog_full,
    output bts_pkg::tape_cmd_t                tape_cmd,
    output logic [CELL_BITS-1:0]              tape_wdata,
    input  logic [CELL_BITS-1:0]              tape_rdata,
    input  bts_pkg::tape_stat_t               tape_stat
);

    localparam int PC_W = $clog2(PROG_DEPTH + 1);
    localparam int PA_W = $clog2(PROG_DEPTH);

    bts_pkg::state_t      state_reg;
    bts_pkg::state_t      state_next;
    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      pc_next;
    logic [PC_W-1:0]      sidx_reg;
    logic [PC_W-1:0]      sidx_next;
    logic [PC_W-1:0]      depth_reg;
    logic [PC_W-1:0]      depth_next;
    logic                 back_reg;
    logic                 back_next;
    logic [CELL_BITS-1:0] ival_reg;
    logic [CELL_BITS-1:0] ival_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [31:0]          value_reg;
    logic [31:0]          value_next;
    logic                 took_reg;
    logic                 took_next;
    logic                 full_reg;
    logic                 full_next;

    logic                 accept;
    logic                 runnable;
    logic                 cell_zero;
    logic                 fwd_jump;
    logic                 back_jump;
    logic [PC_W-1:0]      scan_cand;
    logic                 scan_ok;
    logic                 scan_same;
    logic                 scan_other;
    logic                 scan_match;
    logic signed [63:0]   ival_wide;
    logic signed [63:0]   cell_wide;

    assign busy            = (state_reg != bts_pkg::ST_IDLE);
    assign accept          = start && !busy;
    assign runnable        = (pc_reg < prog_len);
    assign cell_zero       = (tape_rdata == '0);
    assign fwd_jump        = (prog_rdata == bts_pkg::CH_OPEN) && cell_zero;
    assign back_jump       = (prog_rdata == bts_pkg::CH_CLOSE) && !cell_zero;
    assign scan_cand       = back_reg ? sidx_reg - PC_W'(1) : sidx_reg + PC_W'(1);
    assign scan_ok         = back_reg ? (sidx_reg != '0) : (scan_cand < prog_len);
    assign scan_same       = (prog_rdata == (back_reg ? bts_pkg::CH_CLOSE : bts_pkg::CH_OPEN));
    assign scan_other      = (prog_rdata == (back_reg ? bts_pkg::CH_OPEN : bts_pkg::CH_CLOSE));
    assign scan_match      = scan_other && (depth_reg == PC_W'(1));
    assign ival_wide       = 64'(input_value);
    assign cell_wide       = 64'($signed(tape_rdata));

    assign done            = done_reg;
    assign out_valid       = valid_reg;
    assign out_value       = value_reg;
    assign took_input      = took_reg;
    assign load_full       = full_reg;
    assign halted          = (pc_reg >= prog_len);
    assign program_counter = 11'(pc_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bts_pkg::ST_INIT:
            begin
                if (tape_stat.sweep_last)
                begin
                    state_next = bts_pkg::ST_IDLE;
                end
            end
            bts_pkg::ST_IDLE:
            begin
                if (accept && (op == bts_pkg::OP_RESTART))
                begin
                    state_next = bts_pkg::ST_CLEAR;
                end
                else if (accept && (op == bts_pkg::OP_STEP) && runnable)
                begin
                    state_next = bts_pkg::ST_EXEC;
                end
            end
            bts_pkg::ST_CLEAR:
            begin
                if (tape_stat.sweep_last)
                begin
                    state_next = bts_pkg::ST_IDLE;
                end
            end
            bts_pkg::ST_EXEC:
            begin
                if (fwd_jump || back_jump)
                begin
                    state_next = bts_pkg::ST_SCAN_RD;
                end
                else
                begin
                    state_next = bts_pkg::ST_IDLE;
                end
            end
            bts_pkg::ST_SCAN_RD:
            begin
                state_next = scan_ok ? bts_pkg::ST_SCAN_EX : bts_pkg::ST_IDLE;
            end
            bts_pkg::ST_SCAN_EX:
            begin
                state_next = scan_match ? bts_pkg::ST_IDLE : bts_pkg::ST_SCAN_RD;
            end
            default:
            begin
                state_next = bts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prog_cmd   = '0;
        tape_cmd   = '0;
        tape_wdata = tape_rdata;
        prog_raddr = pc_reg[PA_W-1:0];
        pc_next    = pc_reg;
        sidx_next  = sidx_reg;
        depth_next = depth_reg;
        back_next  = back_reg;
        ival_next  = ival_reg;
        done_next  = 1'b0;
        valid_next = 1'b0;
        value_next = '0;
        took_next  = 1'b0;
        full_next  = 1'b0;
        unique case (state_reg)
            bts_pkg::ST_INIT:
            begin
                tape_cmd.sweep = 1'b1;
            end
            bts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ival_next = ival_wide[CELL_BITS-1:0];
                    unique case (op)
                        bts_pkg::OP_APPEND:
                        begin
                            prog_cmd.append = 1'b1;
                            full_next       = prog_full;
                            done_next       = 1'b1;
                        end
                        bts_pkg::OP_RESTART:
                        begin
                            tape_cmd.ptr_zero = 1'b1;
                            pc_next           = '0;
                        end
                        bts_pkg::OP_STEP:
                        begin
                            done_next = !runnable;
                        end
                        bts_pkg::OP_CLEAR:
                        begin
                            prog_cmd.clear = 1'b1;
                            pc_next        = '0;
                            done_next      = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            bts_pkg::ST_CLEAR:
            begin
                tape_cmd.sweep = 1'b1;
                done_next      = tape_stat.sweep_last;
            end
            bts_pkg::ST_EXEC:
            begin
                pc_next   = pc_reg + PC_W'(1);
                done_next = 1'b1;
                unique case (prog_rdata)
                    bts_pkg::CH_PLUS:
                    begin
                        tape_cmd.wr = 1'b1;
                        tape_wdata  = tape_rdata + CELL_BITS'(1);
                    end
                    bts_pkg::CH_MINUS:
                    begin
                        tape_cmd.wr = 1'b1;
                        tape_wdata  = tape_rdata - CELL_BITS'(1);
                    end
                    bts_pkg::CH_RIGHT:
                    begin
                        tape_cmd.ptr_inc = 1'b1;
                    end
                    bts_pkg::CH_LEFT:
                    begin
                        tape_cmd.ptr_dec = 1'b1;
                    end
                    bts_pkg::CH_LOAD:
                    begin
                        tape_cmd.wr = 1'b1;
                        tape_wdata  = ival_reg;
                        took_next   = 1'b1;
                    end
                    bts_pkg::CH_EMIT:
                    begin
                        valid_next = 1'b1;
                        value_next = cell_wide[31:0];
                    end
                    bts_pkg::CH_OPEN:
                    begin
                        if (fwd_jump)
                        begin
                            pc_next    = pc_reg;
                            sidx_next  = pc_reg;
                            depth_next = PC_W'(1);
                            back_next  = 1'b0;
                            done_next  = 1'b0;
                        end
                    end
                    bts_pkg::CH_CLOSE:
                    begin
                        if (back_jump)
                        begin
                            pc_next    = pc_reg;
                            sidx_next  = pc_reg;
                            depth_next = PC_W'(1);
                            back_next  = 1'b1;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            bts_pkg::ST_SCAN_RD:
            begin
                prog_raddr = scan_cand[PA_W-1:0];
                if (scan_ok)
                begin
                    sidx_next = scan_cand;
                end
                else
                begin
                    // no matching bracket: fall through
                    pc_next   = pc_reg + PC_W'(1);
                    done_next = 1'b1;
                end
            end
            bts_pkg::ST_SCAN_EX:
            begin
                if (scan_same)
                begin
                    depth_next = depth_reg + PC_W'(1);
                end
                else if (scan_match)
                begin
                    pc_next   = sidx_reg + PC_W'(1);
                    done_next = 1'b1;
                end
                else if (scan_other)
                begin
                    depth_next = depth_reg - PC_W'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bts_pkg::ST_INIT;
            pc_reg    <= '0;
            sidx_reg  <= '0;
            depth_reg <= '0;
            back_reg  <= 1'b0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            value_reg <= '0;
            took_reg  <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sidx_reg  <= sidx_next;
            depth_reg <= depth_next;
            back_reg  <= back_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            value_reg <= value_next;
            took_reg  <= took_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ival_reg <= ival_next;
    end

endmodule

// ===== rtl/bracket_tape_machine.sv =====
// bracket_tape_machine: tape machine running bracket programs from a program store.
// command channel: start with op, program_char and input_value; a transfer takes
// place at a rising edge with start high and busy low.
// result channel: done is high for exactly one cycle, with out_valid, out_value,
// took_input, halted, load_full and program_counter valid in that cycle; the
// receiver cannot stall, so every result must be taken when done is high.
// work between one transfer and the next:
//   append, clear program, step past end of program: answered from idle
//   step of a simple instruction: program and tape read at the transfer,
//   modify and write back in the following cycle
//   bracket jump: one program store read and one compare per program character
//   scanned, matching bracket included; one more program store read when no
//   matching bracket is found
//   restart: waits for the clearing pass over the tape memory
// result appears in the same cycle in which the next transfer can take place.
// after reset, busy stays high while the tape is cleared;
// the program store holds no valid program until characters are appended.
module bracket_tape_machine #(
    parameter int NUM_CELLS  = 16,
    parameter int PROG_DEPTH = 1024,
    parameter int CELL_BITS  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [7:0]         program_char,
    input  logic signed [31:0] input_value,
    output logic               done,
    output logic               out_valid,
    output logic signed [31:0] out_value,
    output logic               took_input,
    output logic               halted,
    output logic               load_full,
    output logic [10:0]        program_counter
);

    localparam int PC_W = $clog2(PROG_DEPTH + 1);
    localparam int PA_W = $clog2(PROG_DEPTH);

    bts_pkg::prog_cmd_t   prog_cmd;
    logic [PA_W-1:0]      prog_raddr;
    logic [7:0]           prog_rdata;
    logic [PC_W-1:0]      prog_len;
    logic                 prog_full;
    bts_pkg::tape_cmd_t   tape_cmd;
    logic [CELL_BITS-1:0] tape_wdata;
    logic [CELL_BITS-1:0] tape_rdata;
    bts_pkg::tape_stat_t  tape_stat;

    bts_prog_store #(
        .PROG_DEPTH (PROG_DEPTH)
    ) u_prog_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (prog_cmd),
        .wchar (program_char),
        .raddr (prog_raddr),
        .rdata (prog_rdata),
        .len   (prog_len),
        .full  (prog_full)
    );

    bts_tape #(
        .NUM_CELLS (NUM_CELLS),
        .CELL_BITS (CELL_BITS)
    ) u_tape (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tape_cmd),
        .wdata (tape_wdata),
        .rdata (tape_rdata),
        .stat  (tape_stat)
    );

    bts_ctrl #(
        .PROG_DEPTH (PROG_DEPTH),
        .CELL_BITS  (CELL_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .input_value     (input_value),
        .done            (done),
        .out_valid       (out_valid),
        .out_value       (out_value),
        .took_input      (took_input),
        .halted          (halted),
        .load_full       (load_full),
        .program_counter (program_counter),
        .prog_cmd        (prog_cmd),
        .prog_raddr      (prog_raddr),
        .prog_rdata      (prog_rdata),
        .prog_len        (prog_len),
        .prog_full       (prog_full),
        .tape_cmd        (tape_cmd),
        .tape_wdata      (tape_wdata),
        .tape_rdata      (tape_rdata),
        .tape_stat       (tape_stat)
    );

endmodule

// ===== dv/bracket_tape_machine_tb.sv =====
module bracket_tape_machine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCELLS      = 16;
    localparam int PROG_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_WAIT  = 100;

    localparam logic [7:0]  CH_NOP  = 8'h78;
    localparam logic [7:0]  CH_DUMP = 8'h3F;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ONE = 32'h0000_0001;
    localparam logic [31:0] VAL_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic        took;
        logic        halted;
        logic        full;
        logic [10:0] pc;
    } tape_result_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [1:0]         op           = bts_pkg::OP_APPEND;
    logic [7:0]         program_char = '0;
    logic signed [31:0] input_value  = '0;
    logic               done;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               took_input;
    logic               halted;
    logic               load_full;
    logic [10:0]        program_counter;

    logic [7:0]  prog_mem [PROG_DEPTH];
    int          prog_len = 0;
    int          exec_pc  = 0;
    logic [31:0] tape [NCELLS];
    int          cell_ptr = 0;

    tape_result_t expected_results [$];
    int           idle_pct     = 0;
    int           items_sent   = 0;
    int           results_seen = 0;
    int           errors       = 0;
    int           cycles       = 0;

    bracket_tape_machine DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .program_char    (program_char),
        .input_value     (input_value),
        .done            (done),
        .out_valid       (out_valid),
        .out_value       (out_value),
        .took_input      (took_input),
        .halted          (halted),
        .load_full       (load_full),
        .program_counter (program_counter)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        foreach (tape[i])
            tape[i] = '0;
    end

    function automatic int match_forward(int from);
        int depth;
        depth = 1;
        for (int j = from + 1; j < prog_len; j++)
        begin
            if (prog_mem[j] == bts_pkg::CH_OPEN)
                depth++;
            else if (prog_mem[j] == bts_pkg::CH_CLOSE)
            begin
                depth--;
                if (depth == 0)
                    return j + 1;
            end
        end
        return from + 1;
    endfunction

    function automatic int match_backward(int from);
        int depth;
        depth = 1;
        for (int j = from - 1; j >= 0; j--)
        begin
            if (prog_mem[j] == bts_pkg::CH_CLOSE)
                depth++;
            else if (prog_mem[j] == bts_pkg::CH_OPEN)
            begin
                depth--;
                if (depth == 0)
                    return j + 1;
            end
        end
        return from + 1;
    endfunction

    task automatic tape_machine_step(input bts_pkg::op_t o, input logic [7:0] ch,
                                     input logic [31:0] val, output tape_result_t r);
        int nxt;
        r = '0;
        case (o)
            bts_pkg::OP_APPEND:
            begin
                if (prog_len < PROG_DEPTH)
                begin
                    prog_mem[prog_len] = ch;
                    prog_len++;
                end
                else
                    r.full = 1'b1;
            end
            bts_pkg::OP_RESTART:
            begin
                foreach (tape[i])
                    tape[i] = '0;
                cell_ptr = 0;
                exec_pc  = 0;
            end
            bts_pkg::OP_CLEAR:
            begin
                prog_len = 0;
                exec_pc  = 0;
            end
            default:
            begin
                if (exec_pc < prog_len)
                begin
                    nxt = exec_pc + 1;
                    case (prog_mem[exec_pc])
                        bts_pkg::CH_PLUS:  tape[cell_ptr] = tape[cell_ptr] + 32'd1;
                        bts_pkg::CH_MINUS: tape[cell_ptr] = tape[cell_ptr] - 32'd1;
                        bts_pkg::CH_RIGHT: cell_ptr = (cell_ptr + 1) % NCELLS;
                        bts_pkg::CH_LEFT:
                            cell_ptr = (cell_ptr == 0) ? NCELLS - 1 : cell_ptr - 1;
                        bts_pkg::CH_LOAD:
                        begin
                            tape[cell_ptr] = val;
                            r.took = 1'b1;
                        end
                        bts_pkg::CH_EMIT:
                        begin
                            r.valid = 1'b1;
                            r.value = tape[cell_ptr];
                        end
                        bts_pkg::CH_OPEN:
                        begin
                            if (tape[cell_ptr] == '0)
                                nxt = match_forward(exec_pc);
                        end
                        bts_pkg::CH_CLOSE:
                        begin
                            if (tape[cell_ptr] != '0)
                                nxt = match_backward(exec_pc);
                        end
                        default: ;
                    endcase
                    exec_pc = nxt;
                end
            end
        endcase
        r.halted = (exec_pc >= prog_len);
        r.pc     = exec_pc[10:0];
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on result %0d, %s: got %0h, want %0h",
                 results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        tape_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no transfer pending", '0, '0);
            else
            begin
                want = expected_results.pop_front();
                if (out_valid !== want.valid)
                    report_mismatch("out_valid", 32'(out_valid), 32'(want.valid));
                if (out_value !== want.value)
                    report_mismatch("out_value", out_value, want.value);
                if (took_input !== want.took)
                    report_mismatch("took_input", 32'(took_input), 32'(want.took));
                if (halted !== want.halted)
                    report_mismatch("halted", 32'(halted), 32'(want.halted));
                if (load_full !== want.full)
                    report_mismatch("load_full", 32'(load_full), 32'(want.full));
                if (program_counter !== want.pc)
                    report_mismatch("program_counter", 32'(program_counter), 32'(want.pc));
            end
            results_seen++;
        end
    end

    task automatic send_item(input bts_pkg::op_t o, input logic [7:0] ch,
                             input logic [31:0] val);
        int gap;
        tape_result_t r;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= o;
        program_char <= ch;
        input_value  <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        tape_machine_step(o, ch, val, r);
        expected_results.push_back(r);
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic load_program(input logic [7:0] text [$]);
        foreach (text[i])
            send_item(bts_pkg::OP_APPEND, text[i], $urandom);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] random_value();
        if ($urandom_range(9) != 0)
            return $urandom;
        case ($urandom_range(4))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_ONE;
            3: return VAL_NEG;
            default: return '0;
        endcase
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 14) return bts_pkg::CH_PLUS;
        if (r < 24) return bts_pkg::CH_MINUS;
        if (r < 34) return bts_pkg::CH_RIGHT;
        if (r < 44) return bts_pkg::CH_LEFT;
        if (r < 54) return bts_pkg::CH_LOAD;
        if (r < 66) return bts_pkg::CH_EMIT;
        if (r < 78) return bts_pkg::CH_OPEN;
        if (r < 90) return bts_pkg::CH_CLOSE;
        return rand_byte();
    endfunction

    task automatic test_empty_program();
        send_item(bts_pkg::OP_STEP, rand_byte(), random_value());
        send_item(bts_pkg::OP_CLEAR, rand_byte(), random_value());
        send_item(bts_pkg::OP_RESTART, rand_byte(), random_value());
        send_item(bts_pkg::OP_STEP, rand_byte(), random_value());
    endtask

    task automatic test_simple_ops();
        logic [7:0] text [$];
        text = '{bts_pkg::CH_LOAD, bts_pkg::CH_EMIT, bts_pkg::CH_MINUS, bts_pkg::CH_EMIT,
                 bts_pkg::CH_LEFT, bts_pkg::CH_EMIT, bts_pkg::CH_RIGHT, bts_pkg::CH_RIGHT,
                 bts_pkg::CH_PLUS, bts_pkg::CH_EMIT, bts_pkg::CH_LOAD, bts_pkg::CH_PLUS,
                 bts_pkg::CH_EMIT, CH_DUMP, CH_NOP};
        load_program(text);
        send_item(bts_pkg::OP_RESTART, '0, '0);
        send_item(bts_pkg::OP_STEP, '0, VAL_MIN);
        repeat (9) send_item(bts_pkg::OP_STEP, '0, '0);
        send_item(bts_pkg::OP_STEP, '1, VAL_MAX);
        repeat (5) send_item(bts_pkg::OP_STEP, '1, '1);
    endtask

    // nested skip, loop with backward jump, unmatched close and open
    task automatic test_brackets();
        logic [7:0] text [$];
        text = '{bts_pkg::CH_OPEN, bts_pkg::CH_OPEN, bts_pkg::CH_CLOSE, bts_pkg::CH_CLOSE,
                 bts_pkg::CH_PLUS, bts_pkg::CH_PLUS, bts_pkg::CH_OPEN, bts_pkg::CH_MINUS,
                 bts_pkg::CH_CLOSE, bts_pkg::CH_PLUS, bts_pkg::CH_CLOSE, bts_pkg::CH_MINUS,
                 bts_pkg::CH_OPEN};
        send_item(bts_pkg::OP_CLEAR, '0, '0);
        load_program(text);
        send_item(bts_pkg::OP_RESTART, '0, '0);
        repeat (16) send_item(bts_pkg::OP_STEP, rand_byte(), random_value());
    endtask

    task automatic test_clear_keeps_tape();
        logic [7:0] text [$];
        text = '{bts_pkg::CH_PLUS, bts_pkg::CH_PLUS, bts_pkg::CH_RIGHT, bts_pkg::CH_MINUS};
        send_item(bts_pkg::OP_CLEAR, '0, '0);
        load_program(text);
        send_item(bts_pkg::OP_RESTART, '0, '0);
        repeat (4) send_item(bts_pkg::OP_STEP, '0, '0);
        send_item(bts_pkg::OP_CLEAR, '0, '0);
        send_item(bts_pkg::OP_STEP, '0, '0);
        wait_drained();
        text = '{bts_pkg::CH_EMIT, bts_pkg::CH_LEFT, bts_pkg::CH_EMIT};
        load_program(text);
        repeat (4) send_item(bts_pkg::OP_STEP, '0, '0);
    endtask

    // store full, and a forward scan across the whole store
    task automatic test_store_full();
        send_item(bts_pkg::OP_CLEAR, '0, '0);
        send_item(bts_pkg::OP_APPEND, bts_pkg::CH_OPEN, '0);
        repeat (PROG_DEPTH - 2) send_item(bts_pkg::OP_APPEND, bts_pkg::CH_PLUS, '0);
        send_item(bts_pkg::OP_APPEND, bts_pkg::CH_CLOSE, '0);
        send_item(bts_pkg::OP_APPEND, rand_byte(), '0);
        send_item(bts_pkg::OP_RESTART, '0, '0);
        send_item(bts_pkg::OP_STEP, '0, '0);
        send_item(bts_pkg::OP_STEP, '0, '0);
        send_item(bts_pkg::OP_CLEAR, '0, '0);
    endtask

    task automatic random_session();
        logic [7:0] c;
        int len;
        int depth;
        int steps;
        int r;
        bit broken;
        if (prog_len > 200 || $urandom_range(9) != 0)
            send_item(bts_pkg::OP_CLEAR, rand_byte(), $urandom);
        len    = $urandom_range(40, 2);
        broken = ($urandom_range(9) == 0);
        depth  = 0;
        repeat (len)
        begin
            c = random_char();
            if (c == bts_pkg::CH_OPEN)
                depth++;
            else if (c == bts_pkg::CH_CLOSE)
            begin
                if (depth > 0)
                    depth--;
                else if (!broken)
                    c = bts_pkg::CH_EMIT;
            end
            send_item(bts_pkg::OP_APPEND, c, $urandom);
        end
        if (!broken)
            repeat (depth) send_item(bts_pkg::OP_APPEND, bts_pkg::CH_CLOSE, $urandom);
        if ($urandom_range(4) != 0)
            send_item(bts_pkg::OP_RESTART, rand_byte(), $urandom);
        steps = $urandom_range(3 * len + 4, len);
        repeat (steps)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_item(bts_pkg::OP_RESTART, rand_byte(), $urandom);
            else if (r < 7)
                send_item(bts_pkg::OP_APPEND, rand_byte(), $urandom);
            else if (r < 9)
                send_item(bts_pkg::OP_CLEAR, rand_byte(), $urandom);
            else
                send_item(bts_pkg::OP_STEP, rand_byte(), random_value());
        end
        if ($urandom_range(19) == 0)
            wait_drained();
    endtask

    task automatic test_random(int pct, int quota);
        int target;
        idle_pct = pct;
        target   = items_sent + quota;
        while (items_sent < target)
            random_session();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 38;
        test_empty_program();
        test_simple_ops();
        test_brackets();
        test_clear_keeps_tape();
        test_store_full();
        test_random(38, 200);
        test_random(51, 200);
        test_random(0, 200);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
